// ===== rtl/sorted_hash_table_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_hash_table_lookup assertion macros
// shared concurrent assertion forms for the lookup block
// ----------------------------------------------------------------------------
`ifndef SORTED_HASH_TABLE_LOOKUP_ASSERT_SVH
`define SORTED_HASH_TABLE_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SHTL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SHTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/shtl_pkg.sv =====
// ----------------------------------------------------------------------------
// shtl_pkg
// shared types and constants of the sorted key table lookup
// ----------------------------------------------------------------------------
`default_nettype none

package shtl_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int KEY_W           = 64;
   localparam int ENTRY_W         = 2 * KEY_W;
   localparam int ACTION_W        = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic append;
      logic start;
      logic step;
      logic load;
      logic hit;
      logic error;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type action;
      logic       full;
      logic       empty;
      logic       found;
      logic       more;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/shtl_ram.sv =====
// ----------------------------------------------------------------------------
// shtl_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module shtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/shtl_ctrl.sv =====
// ----------------------------------------------------------------------------
// shtl_ctrl
// sequencer for append, clear and binary search probes
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_hash_table_lookup_assert.svh"

module shtl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire shtl_pkg::status_type status,
   output shtl_pkg::cmd_type         cmd
);

   import shtl_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (status.action)
                  ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                     cmd.load  = 1'b1;
                  end
                  ACT_APPEND: begin
                     cmd.append = !status.full;
                     cmd.error  = status.full;
                     cmd.load   = 1'b1;
                  end
                  ACT_QUERY: begin
                     if (status.empty) begin
                        cmd.load = 1'b1;
                     end else begin
                        cmd.start = 1'b1;
                        state_in  = ST_SEARCH;
                     end
                  end
                  default: begin
                     cmd.load = 1'b1;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.found || !status.more) begin
               cmd.load = 1'b1;
               cmd.hit  = status.found;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // the output word is empty for the whole search
   `SHTL_ASSERT_NOW(a_search_no_rsp, clock, reset, state_ff == ST_SEARCH, !rsp_valid_ff, "response pending during search")
   // a finished item always shows a word next cycle
   `SHTL_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load, rsp_valid_ff, "loaded response not shown")
   // at most one table operation per cycle
   `SHTL_ASSERT_NOW(a_one_op, clock, reset, 1'b1, $onehot0({cmd.clear, cmd.append, cmd.start, cmd.step}), "conflicting table commands")

endmodule

`default_nettype wire

// ===== rtl/shtl_dp.sv =====
// ----------------------------------------------------------------------------
// shtl_dp
// key store, entry count, search bounds and response word
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_hash_table_lookup_assert.svh"

module shtl_dp #(
   parameter int TABLE_DEPTH = shtl_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic [shtl_pkg::ACTION_W-1:0]            req_action,
   input  wire logic [shtl_pkg::KEY_W-1:0]               req_key_high,
   input  wire logic [shtl_pkg::KEY_W-1:0]               req_key_low,
   input  wire shtl_pkg::cmd_type                        cmd,
   output shtl_pkg::status_type                          status,
   output logic                                          rsp_hit,
   output logic                                          rsp_error
);

   import shtl_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      left_ff, right_ff;
   logic [CW-1:0]      mid_ff;
   logic [ENTRY_W-1:0] key_ff;
   logic               hit_ff, error_ff;

   logic [ENTRY_W-1:0] rd_data;
   logic               key_lt, key_eq;
   logic [CW-1:0]      left_in, right_in, next_mid;
   logic [CW-1:0]      rd_addr_full;

   // probe compare against the entry read last cycle
   assign key_eq   = (key_ff == rd_data);
   assign key_lt   = (key_ff < rd_data);
   assign left_in  = key_lt ? left_ff : mid_ff + CW'(1);
   assign right_in = key_lt ? mid_ff : right_ff;
   assign next_mid = left_in + ((right_in - left_in) >> 1);

   assign rd_addr_full = cmd.start ? (count_ff >> 1) : next_mid;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff   <= {req_key_high, req_key_low};
         left_ff  <= '0;
         right_ff <= count_ff;
      end else if (cmd.step) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
      if (cmd.start || cmd.step) begin
         mid_ff <= rd_addr_full;
      end
      if (cmd.load) begin
         hit_ff   <= cmd.hit;
         error_ff <= cmd.error;
      end
   end

   shtl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_key_high, req_key_low}),
      .rd_en   (cmd.start || cmd.step),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      status.action = action_type'(req_action);
      status.full   = (count_ff == CW'(TABLE_DEPTH));
      status.empty  = (count_ff == '0);
      status.found  = key_eq;
      status.more   = (left_in < right_in);
   end

   assign rsp_hit   = hit_ff;
   assign rsp_error = error_ff;

   // entry count never passes the table size
   `SHTL_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH), "entry count overflow")
   // every probe reads inside the live range
   `SHTL_ASSERT_NOW(a_probe_range, clock, reset, cmd.step, (mid_ff >= left_ff) && (mid_ff < right_ff), "probe outside search range")
   // a search range never reaches beyond the stored entries
   `SHTL_ASSERT_NOW(a_right_bound, clock, reset, cmd.step, right_ff <= count_ff, "search past entry count")

endmodule

`default_nettype wire

// ===== rtl/sorted_hash_table_lookup.sv =====
// ----------------------------------------------------------------------------
// sorted_hash_table_lookup
// membership lookup over an ascending table of 128-bit keys
// ----------------------------------------------------------------------------
// usage
//   req channel: req_action (clear, append, query), req_key_high, req_key_low
//   rsp channel: rsp_hit, rsp_error; exactly one word per request word
//   keys compare as 128-bit unsigned values, key_high the upper half
//   clear and append (and the unused action) answer in the cycle after the
//   request is taken; an append to a full table stores nothing, error set
//   a query runs a binary search, one ram read and compare per cycle, and
//   answers once the key is found or the search range is empty; an empty
//   table answers in the cycle after the query is taken
//   one request in flight at a time: the next one is taken in the cycle
//   the previous answer sits in the output register and is being taken
//   (or has been), so a stalled rsp_ready holds off new requests
//   reset empties the table (entry count to zero) and drops any pending
//   answer; no clearing pass, the store is only read below the count
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_hash_table_lookup #(
   parameter int TABLE_DEPTH = shtl_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [shtl_pkg::ACTION_W-1:0] req_action,
   input  wire logic [shtl_pkg::KEY_W-1:0]    req_key_high,
   input  wire logic [shtl_pkg::KEY_W-1:0]    req_key_low,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_hit,
   output logic                               rsp_error
);

   import shtl_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: handshakes, action decode, probe loop control
   shtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // key store, bounds, compare and response payload
   shtl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_action   (req_action),
      .req_key_high (req_key_high),
      .req_key_low  (req_key_low),
      .cmd          (cmd),
      .status       (status),
      .rsp_hit      (rsp_hit),
      .rsp_error    (rsp_error)
   );

endmodule

`default_nettype wire

// ===== dv/sorted_hash_table_lookup_test.sv =====
// ----------------------------------------------------------------------------
// sorted_hash_table_lookup_test
// self-checking bench for the sorted 128-bit key table lookup: a short
// table of directed words, then random clear / mostly ascending append /
// query sequences, every answer word checked against the typed answer of
// its directed row or an in-bench model (a binary search for queries) over
// its own copy of the table, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------

module sorted_hash_table_lookup_test;
   timeunit 1ns;
   timeprecision 1ps;

   import shtl_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int RANDOM_WORDS = 460;
   // long enough for any word still in flight to show up
   localparam int SETTLE_CYCLES = 20;

   // one answer word as the block gives it
   typedef struct packed {
      logic hit;
      logic error;
   } answer_type;

   // one row of the directed table; typed rows carry their own answer
   typedef struct packed {
      action_type        action;
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic              typed;
      logic              hit;
      logic              error;
   } stim_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action = ACT_NONE;
   logic [KEY_W-1:0]     req_key_high = '0;
   logic [KEY_W-1:0]     req_key_low = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic                 rsp_error;

   // bench copy of the key table
   logic [ENTRY_W-1:0]   key_store [DEPTH];
   int                   table_count = 0;

   answer_type           pending_answers [$];
   int                   mismatches = 0;
   int                   words_sent = 0;
   bit                   send_idle = 1'b1;
   bit                   recv_idle = 1'b1;

   // directed words: extremes of both key halves, every action, the unused
   // action, an out-of-order append and a query after clear
   stim_row_type directed_rows [23] = '{
      '{ACT_QUERY,  64'h0, 64'h0, 1'b1, 1'b0, 1'b0},  // empty table misses
      '{ACT_NONE,   '1, '1, 1'b1, 1'b0, 1'b0},
      '{ACT_APPEND, 64'h0, 64'h0, 1'b1, 1'b0, 1'b0},
      '{ACT_QUERY,  64'h0, 64'h0, 1'b1, 1'b1, 1'b0},
      '{ACT_APPEND, 64'h0, 64'h1, 1'b1, 1'b0, 1'b0},
      '{ACT_APPEND, 64'h0, '1, 1'b1, 1'b0, 1'b0},
      '{ACT_APPEND, 64'h1, 64'h0, 1'b1, 1'b0, 1'b0},
      '{ACT_APPEND, 64'h8000_0000_0000_0000, 64'h0, 1'b1, 1'b0, 1'b0},
      '{ACT_APPEND, '1, '1, 1'b1, 1'b0, 1'b0},
      '{ACT_QUERY,  '1, '1, 1'b0, 1'b0, 1'b0},
      '{ACT_QUERY,  64'h0, '1, 1'b0, 1'b0, 1'b0},
      '{ACT_QUERY,  64'h0, 64'h2, 1'b0, 1'b0, 1'b0},
      '{ACT_QUERY,  64'h8000_0000_0000_0000, 64'h1, 1'b0, 1'b0, 1'b0},
      '{ACT_QUERY,  64'h7fff_ffff_ffff_ffff, '1, 1'b0, 1'b0, 1'b0},
      '{ACT_NONE,   64'h0, 64'h0, 1'b1, 1'b0, 1'b0},
      '{ACT_APPEND, 64'h5, 64'h5, 1'b1, 1'b0, 1'b0},  // below the last entry
      '{ACT_QUERY,  64'h5, 64'h5, 1'b0, 1'b0, 1'b0},
      '{ACT_QUERY,  64'h1, 64'h0, 1'b0, 1'b0, 1'b0},
      '{ACT_CLEAR,  '1, '1, 1'b1, 1'b0, 1'b0},
      '{ACT_QUERY,  '1, '1, 1'b1, 1'b0, 1'b0},        // cleared table misses
      '{ACT_APPEND, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0},
      '{ACT_QUERY,  64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b0},
      '{ACT_QUERY,  64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, 1'b0}
   };

   sorted_hash_table_lookup dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_key_high (req_key_high),
      .req_key_low  (req_key_low),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hit      (rsp_hit),
      .rsp_error    (rsp_error)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // hard stop in case the block hangs
   initial begin
      #12_000_000;
      $display("sorted_hash_table_lookup: mismatch");
      $finish;
   end

   // applies one word to the bench table and works out its answer
   function automatic answer_type lookup_predict(action_type act, logic [ENTRY_W-1:0] key);
      answer_type ans;
      int         lo;
      int         hi;
      int         mid;
      bit         found;
      ans = '0;
      case (act)
         ACT_CLEAR: begin
            table_count = 0;
         end
         ACT_APPEND: begin
            // a full table refuses the key and flags it
            if (table_count >= DEPTH) begin
               ans.error = 1'b1;
            end else begin
               key_store[table_count] = key;
               table_count++;
            end
         end
         ACT_QUERY: begin
            // same probe order as the block, so out-of-order tables agree
            lo = 0;
            hi = table_count;
            found = 1'b0;
            while (lo < hi && !found) begin
               mid = lo + (hi - lo) / 2;
               if (key < key_store[mid]) begin
                  hi = mid;
               end else if (key > key_store[mid]) begin
                  lo = mid + 1;
               end else begin
                  found = 1'b1;
               end
            end
            ans.hit = found;
         end
         default: ;  // unused action leaves the table alone
      endcase
      return ans;
   endfunction

   function automatic logic [ENTRY_W-1:0] random_key();
      return {$urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      mismatches++;
   endtask

   // called just after a rising edge; returns in the step the word is taken
   task automatic send_word(input action_type act, input logic [ENTRY_W-1:0] key,
                            input bit typed = 1'b0, input logic t_hit = 1'b0,
                            input logic t_error = 1'b0);
      int         gap;
      answer_type ans;
      gap = send_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_key_high <= key[ENTRY_W-1:KEY_W];
      req_key_low  <= key[KEY_W-1:0];
      do @(posedge clock); while (req_ready !== 1'b1);
      ans = lookup_predict(act, key);
      // typed rows trust the table, the bench copy is still kept in step
      if (typed) begin
         ans.hit   = t_hit;
         ans.error = t_error;
      end
      pending_answers.push_back(ans);
      words_sent++;
   endtask

   // sender holds off until every answer word is back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic check_answer();
      answer_type want;
      if (pending_answers.size() == 0) begin
         report_mismatch("answer word with nothing pending");
      end else begin
         want = pending_answers.pop_front();
         if (rsp_hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", rsp_hit, want.hit));
         if (rsp_error !== want.error)
            report_mismatch($sformatf("error %b, want %b", rsp_error, want.error));
      end
   endtask

   // answer side: check each taken word, then stall a random number of cycles
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            check_answer();
            stall_left = recv_idle ? $urandom_range(0, 19) : 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // request side
   initial begin
      logic [ENTRY_W-1:0] next_key;
      logic [ENTRY_W-1:0] step;
      int                 n_append;
      int                 n_query;
      int                 idx;
      int                 stop_at;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].action,
                   {directed_rows[i].key_high, directed_rows[i].key_low},
                   directed_rows[i].typed, directed_rows[i].hit, directed_rows[i].error);
      end
      wait_for_answers();

      // random sequences: clear, mostly ascending appends, then mostly queries
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         send_idle = $urandom_range(0, 3) != 0;
         recv_idle = $urandom_range(0, 3) != 0;
         send_word(ACT_CLEAR, random_key());
         n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(0, 24);
         next_key = random_key() >> $urandom_range(0, 127);
         for (int i = 0; i < n_append; i++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_word(ACT_APPEND, random_key());    // likely out of order
            end else begin
               send_word(ACT_APPEND, next_key);
               // shift mixes low-half-only steps, high-half steps and repeats
               step = ($urandom_range(0, 7) == 0) ? '0
                                                  : random_key() >> $urandom_range(0, 127);
               next_key = next_key + step;
            end
         end
         n_query = $urandom_range(4, 30);
         for (int i = 0; i < n_query; i++) begin
            idx = (table_count > 0) ? $urandom_range(0, table_count - 1) : 0;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  if (table_count > 0) send_word(ACT_QUERY, key_store[idx]);
                  else send_word(ACT_QUERY, random_key());
               end
               6: begin
                  if (table_count > 0) begin
                     if ($urandom_range(0, 1) == 1) send_word(ACT_QUERY, key_store[idx] + 1);
                     else send_word(ACT_QUERY, key_store[idx] - 1);
                  end else begin
                     send_word(ACT_QUERY, random_key());
                  end
               end
               7: send_word(ACT_QUERY, random_key());
               8: send_word(ACT_NONE, random_key());
               default: begin
                  send_word(ACT_APPEND, next_key);
                  next_key = next_key + (random_key() >> $urandom_range(0, 127));
               end
            endcase
         end
         if ($urandom_range(0, 3) == 0) wait_for_answers();
      end

      // drain and let any straggler show up
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sorted_hash_table_lookup: match");
      end else begin
         $display("sorted_hash_table_lookup: mismatch");
      end
      $finish;
   end

endmodule
